FILE: hdl/brle_pkg.sv
package brle_pkg;

  localparam int DATA_W     = 8;
  localparam int LIMIT_W    = 7;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_USER_W = 4;

  localparam logic [DATA_W-1:0] CH_NL   = 8'h0A;
  localparam logic [DATA_W-1:0] CH_CR   = 8'h0D;
  localparam logic [DATA_W-1:0] CH_NULL = 8'h00;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef struct packed {
    logic              stop;
    logic              emit;
    logic              pop;
    logic              ok;
    logic              nl_pop;
    logic [DATA_W-1:0] ch;
  } step_res_t;

endpackage

FILE: hdl/brle_store.sv
module brle_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [brle_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [brle_pkg::DATA_W-1:0] rdata
);

  logic [brle_pkg::DATA_W-1:0] mem [DEPTH];
  logic [brle_pkg::DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/brle_step.sv
module brle_step (
  input  logic                        rem_zero,
  input  logic                        rem_one,
  input  logic [brle_pkg::DATA_W-1:0] byte_in,
  output brle_pkg::step_res_t         res
);

  always_comb begin
    res = '0;
    if (rem_zero) begin
      res.stop = 1'b1;
    end else if (rem_one && byte_in != brle_pkg::CH_NL) begin
      res.stop = 1'b1;
      res.emit = 1'b1;
      res.ok   = 1'b1;
      res.ch   = brle_pkg::CH_NULL;
    end else begin
      res.pop  = 1'b1;
      res.emit = 1'b1;
      if (byte_in == brle_pkg::CH_NL) begin
        res.stop   = 1'b1;
        res.ok     = 1'b1;
        res.nl_pop = 1'b1;
        res.ch     = brle_pkg::CH_NULL;
      end else if (byte_in == brle_pkg::CH_CR) begin
        res.ch = brle_pkg::CH_NULL;
      end else begin
        res.ch = byte_in;
      end
    end
  end

endmodule

FILE: hdl/byte_ring_line_extractor.sv
// Circular line buffer over a byte store of DEPTH entries. An append item
// (in_tuser 0) stores one byte unless full and gives one result in the next
// cycle. A remove item (in_tuser 1) pops one line of at most line_limit
// characters, saturated to MAX_LINE, and gives one result per character, or
// one report-only result when it pops nothing. A remove makes two passes
// over the line through the store's read port: a scan pass that finds where
// the line ends and updates the pointers, then an emit pass that sends the
// characters. Each pass takes one byte at a time: a registered store read in
// S_WAIT, then the shared step unit in S_EVAL. The emit pass waits on output
// stalls. The block takes no new item until its last result has been taken.
// The store is not cleared after reset; only written entries are ever used.
module byte_ring_line_extractor #(
  parameter int DEPTH    = 256,
  parameter int MAX_LINE = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [brle_pkg::IN_DATA_W-1:0]      in_tdata,  // data_byte, line_limit, pad
  input  logic [0:0]                          in_tuser,  // cmd
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [brle_pkg::DATA_W-1:0]         out_tdata, // line_char
  output logic [brle_pkg::OUT_USER_W-1:0]     out_tuser, // char_valid, ok, is_full, has_data
  output logic                                out_tlast
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = brle_pkg::LIMIT_W;
  localparam int DW = brle_pkg::DATA_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WAIT   = 2'd1;
  localparam logic [1:0] S_EVAL   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] nl_r, nl_nxt;

  logic [DW-1:0] out_data_r, out_data_nxt;
  logic          out_cv_r, out_cv_nxt;
  logic          out_ok_r, out_ok_nxt;
  logic          out_full_r, out_full_nxt;
  logic          out_has_r, out_has_nxt;
  logic          out_last_r, out_last_nxt;

  logic [AW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [AW-1:0] start_pos_r, start_pos_nxt;
  logic [CW-1:0] start_rem_r, start_rem_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic [LW-1:0] lim_r, lim_nxt;
  logic [LW-1:0] etot_r, etot_nxt;
  logic [LW-1:0] ecnt_r, ecnt_nxt;
  logic          pass_r, pass_nxt;
  logic          ok_fin_r, ok_fin_nxt;

  logic          in_cmd;
  logic [DW-1:0] in_byte;
  logic [LW-1:0] in_limit;
  logic [LW-1:0] lim_sat;
  logic          full;
  logic          store_we;
  logic [DW-1:0] rdata;
  logic [AW-1:0] pos_step;
  logic [CW-1:0] rem_step;
  logic          out_free;
  logic          last_emit;
  brle_pkg::step_res_t st;

  assign in_cmd   = in_tuser[0];
  assign in_byte  = in_tdata[DW-1:0];
  assign in_limit = in_tdata[DW+LW-1:DW];
  assign lim_sat  = (in_limit > LW'(MAX_LINE)) ? LW'(MAX_LINE) : in_limit;
  assign full     = (fill_r == CW'(DEPTH));
  assign out_free = !out_valid_r || out_tready;

  assign in_tready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {out_has_r, out_full_r, out_ok_r, out_cv_r};
  assign out_tlast  = out_last_r;

  brle_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (wp_r),
    .wdata (in_byte),
    .raddr (pos_r),
    .rdata (rdata)
  );

  brle_step u_step (
    .rem_zero (rem_r == '0),
    .rem_one  (rem_r == CW'(1)),
    .byte_in  (rdata),
    .res      (st)
  );

  always_comb begin
    pos_step  = st.pop ? ((pos_r == AW'(DEPTH - 1)) ? '0 : pos_r + 1'b1) : pos_r;
    rem_step  = st.pop ? rem_r - 1'b1 : rem_r;
    last_emit = ((ecnt_r + 1'b1) == etot_r);
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    fill_nxt      = fill_r;
    nl_nxt        = nl_r;
    out_data_nxt  = out_data_r;
    out_cv_nxt    = out_cv_r;
    out_ok_nxt    = out_ok_r;
    out_full_nxt  = out_full_r;
    out_has_nxt   = out_has_r;
    out_last_nxt  = out_last_r;
    pos_nxt       = pos_r;
    rem_nxt       = rem_r;
    start_pos_nxt = start_pos_r;
    start_rem_nxt = start_rem_r;
    idx_nxt       = idx_r;
    lim_nxt       = lim_r;
    etot_nxt      = etot_r;
    ecnt_nxt      = ecnt_r;
    pass_nxt      = pass_r;
    ok_fin_nxt    = ok_fin_r;
    store_we      = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          if (in_cmd == brle_pkg::CMD_APPEND) begin
            if (!full) begin
              store_we = 1'b1;
              wp_nxt   = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
              fill_nxt = fill_r + 1'b1;
              if (in_byte == brle_pkg::CH_NL) begin
                nl_nxt = nl_r + 1'b1;
              end
            end
            out_valid_nxt = 1'b1;
            out_data_nxt  = brle_pkg::CH_NULL;
            out_cv_nxt    = 1'b0;
            out_last_nxt  = 1'b1;
            out_ok_nxt    = !full;
            out_full_nxt  = (fill_nxt == CW'(DEPTH));
            out_has_nxt   = (fill_nxt != '0);
          end else if (nl_r != '0 || full) begin
            lim_nxt       = lim_sat;
            pos_nxt       = rp_r;
            rem_nxt       = fill_r;
            start_pos_nxt = rp_r;
            start_rem_nxt = fill_r;
            idx_nxt       = '0;
            etot_nxt      = '0;
            ecnt_nxt      = '0;
            pass_nxt      = 1'b0;
            ok_fin_nxt    = 1'b0;
            state_nxt     = S_WAIT;
          end else begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = brle_pkg::CH_NULL;
            out_cv_nxt    = 1'b0;
            out_last_nxt  = 1'b1;
            out_ok_nxt    = 1'b0;
            out_full_nxt  = full;
            out_has_nxt   = (fill_r != '0);
          end
        end
      end
      S_WAIT: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!pass_r) begin
          if (idx_r == lim_r) begin
            rp_nxt    = pos_r;
            fill_nxt  = rem_r;
            state_nxt = S_FINISH;
          end else begin
            if (st.emit) begin
              etot_nxt = etot_r + 1'b1;
            end
            pos_nxt = pos_step;
            rem_nxt = rem_step;
            idx_nxt = idx_r + 1'b1;
            if (st.stop) begin
              ok_fin_nxt = st.ok;
              if (st.nl_pop && nl_r != '0) begin
                nl_nxt = nl_r - 1'b1;
              end
              rp_nxt    = pos_step;
              fill_nxt  = rem_step;
              state_nxt = S_FINISH;
            end else if ((idx_r + 1'b1) == lim_r) begin
              rp_nxt    = pos_step;
              fill_nxt  = rem_step;
              state_nxt = S_FINISH;
            end else begin
              state_nxt = S_WAIT;
            end
          end
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = st.ch;
          out_cv_nxt    = 1'b1;
          out_last_nxt  = last_emit;
          out_ok_nxt    = last_emit && ok_fin_r;
          out_full_nxt  = full;
          out_has_nxt   = (fill_r != '0);
          ecnt_nxt      = ecnt_r + 1'b1;
          pos_nxt       = pos_step;
          rem_nxt       = rem_step;
          state_nxt     = last_emit ? S_IDLE : S_WAIT;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          if (etot_r == '0) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = brle_pkg::CH_NULL;
            out_cv_nxt    = 1'b0;
            out_last_nxt  = 1'b1;
            out_ok_nxt    = 1'b0;
            out_full_nxt  = full;
            out_has_nxt   = (fill_r != '0);
            state_nxt     = S_IDLE;
          end else begin
            pass_nxt  = 1'b1;
            pos_nxt   = start_pos_r;
            rem_nxt   = start_rem_r;
            ecnt_nxt  = '0;
            state_nxt = S_WAIT;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      wp_r        <= '0;
      rp_r        <= '0;
      fill_r      <= '0;
      nl_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      fill_r      <= fill_nxt;
      nl_r        <= nl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_cv_r    <= out_cv_nxt;
    out_ok_r    <= out_ok_nxt;
    out_full_r  <= out_full_nxt;
    out_has_r   <= out_has_nxt;
    out_last_r  <= out_last_nxt;
    pos_r       <= pos_nxt;
    rem_r       <= rem_nxt;
    start_pos_r <= start_pos_nxt;
    start_rem_r <= start_rem_nxt;
    idx_r       <= idx_nxt;
    lim_r       <= lim_nxt;
    etot_r      <= etot_nxt;
    ecnt_r      <= ecnt_nxt;
    pass_r      <= pass_nxt;
    ok_fin_r    <= ok_fin_nxt;
  end

endmodule

FILE: hdl/brle_checker.sv
module brle_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [0:0]                      in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [brle_pkg::DATA_W-1:0]     out_tdata,
  input logic [brle_pkg::OUT_USER_W-1:0] out_tuser,
  input logic                            out_tlast
);

  // A stalled result holds its whole payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // An append item answers in the next cycle with one report-only result.
  a_append_reply: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] == brle_pkg::CMD_APPEND |=>
      out_tvalid && out_tlast && !out_tuser[0])
    else $error("append item gave no single report result");

  // A full store always holds data.
  a_full_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[3])
    else $error("full flag without data flag");

  // A result without a character is the only result of its item and carries zero.
  a_report_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && out_tdata == brle_pkg::CH_NULL)
    else $error("report result malformed");

  // New items are refused while a result is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input ready while a result is pending");

endmodule

bind byte_ring_line_extractor brle_checker u_brle_checker (.*);
